FILE: rtl/rvid_pkg.sv
// ----------------------------------------------------------------------------
// rvid_pkg
// Types, encodings and lookup functions for the RV32I instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rvid_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_SLL     = 3'd1;
  localparam logic [2:0] F3_SRL_SRA = 3'd5;

  // ALU operations
  localparam logic [3:0] ALU_NONE = 4'd0;
  localparam logic [3:0] ALU_ADD  = 4'd1;
  localparam logic [3:0] ALU_SUB  = 4'd2;
  localparam logic [3:0] ALU_SLL  = 4'd3;
  localparam logic [3:0] ALU_LT   = 4'd4;
  localparam logic [3:0] ALU_LTU  = 4'd5;
  localparam logic [3:0] ALU_XOR  = 4'd6;
  localparam logic [3:0] ALU_SRL  = 4'd7;
  localparam logic [3:0] ALU_SRA  = 4'd8;
  localparam logic [3:0] ALU_OR   = 4'd9;
  localparam logic [3:0] ALU_AND  = 4'd10;
  localparam logic [3:0] ALU_EQ   = 4'd11;
  localparam logic [3:0] ALU_NE   = 4'd12;
  localparam logic [3:0] ALU_GE   = 4'd13;
  localparam logic [3:0] ALU_GEU  = 4'd14;
  localparam logic [3:0] ALU_PASS = 4'd15;

  // Operand selection
  localparam logic [1:0] OSEL_REG_REG = 2'd0;
  localparam logic [1:0] OSEL_REG_IMM = 2'd1;
  localparam logic [1:0] OSEL_PC_IMM  = 2'd2;

  // Jump kinds
  localparam logic [2:0] JMP_NONE     = 3'd0;
  localparam logic [2:0] JMP_JAL      = 3'd1;
  localparam logic [2:0] JMP_JALR     = 3'd2;
  localparam logic [2:0] JMP_BR_TAKEN = 3'd3;
  localparam logic [2:0] JMP_BR_NOT   = 3'd4;

  // Memory access kinds
  localparam logic [3:0] MEM_NONE = 4'd0;
  localparam logic [3:0] MEM_LB   = 4'd1;
  localparam logic [3:0] MEM_LH   = 4'd2;
  localparam logic [3:0] MEM_LW   = 4'd3;
  localparam logic [3:0] MEM_LBU  = 4'd4;
  localparam logic [3:0] MEM_LHU  = 4'd5;
  localparam logic [3:0] MEM_SB   = 4'd6;
  localparam logic [3:0] MEM_SH   = 4'd7;
  localparam logic [3:0] MEM_SW   = 4'd8;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc;
    logic        predicted_taken;
  } decode_in_t;

  typedef struct packed {
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic [4:0]         dest_reg;
    logic               writeback_enable;
    logic [3:0]         alu_op;
    logic [1:0]         operand_select;
    logic [2:0]         jump_kind;
    logic signed [31:0] immediate;
    logic [31:0]        branch_target;
    logic [3:0]         mem_access;
    logic               illegal;
  } decode_out_t;

  // funct3 -> ALU op for OP / OP-IMM (base funct7)
  function automatic logic [3:0] arith_alu(input logic [2:0] f3);
    logic [3:0] op;
    case (f3)
      3'd0:    op = ALU_ADD;
      3'd1:    op = ALU_SLL;
      3'd2:    op = ALU_LT;
      3'd3:    op = ALU_LTU;
      3'd4:    op = ALU_XOR;
      3'd5:    op = ALU_SRL;
      3'd6:    op = ALU_OR;
      default: op = ALU_AND;
    endcase
    return op;
  endfunction

  // funct3 -> compare op for branches; NONE marks an undefined code
  function automatic logic [3:0] branch_alu(input logic [2:0] f3);
    logic [3:0] op;
    case (f3)
      3'd0:    op = ALU_EQ;
      3'd1:    op = ALU_NE;
      3'd4:    op = ALU_LT;
      3'd5:    op = ALU_GE;
      3'd6:    op = ALU_LTU;
      3'd7:    op = ALU_GEU;
      default: op = ALU_NONE;
    endcase
    return op;
  endfunction

  // funct3 -> load kind; NONE marks an undefined code
  function automatic logic [3:0] load_kind(input logic [2:0] f3);
    logic [3:0] k;
    case (f3)
      3'd0:    k = MEM_LB;
      3'd1:    k = MEM_LH;
      3'd2:    k = MEM_LW;
      3'd4:    k = MEM_LBU;
      3'd5:    k = MEM_LHU;
      default: k = MEM_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rv32i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// RV32I decode stage: instruction word, pc and prediction in, control fields out.
// ----------------------------------------------------------------------------
//
// Channel   Signals              Direction  Transfer
// --------  -------------------  ---------  -----------------------------------
// command   start, busy, request in         transaction on start && !busy
// result    done, result         out        valid for the one cycle done is high
//
// Path: the command is captured in an input register when it is accepted,
//   decoded by the combinational logic below and captured in the result
//   register, where done rises; the result is taken from the result register.
// Rate: one transaction per clock. busy is never raised, since both stages
//   advance every cycle.
// Reset: rst (synchronous, active high) clears both stage valid bits; the
//   payload registers are not reset.
// Stalls: none; the receiver takes each result in the cycle it is shown.
// The deepest path is the pc + immediate adder for branch_target.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_instruction_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire rvid_pkg::decode_in_t request,
  output logic                      done,
  output rvid_pkg::decode_out_t     result
);
  import rvid_pkg::*;

  // Stage 1: captured command
  logic       in_valid;
  decode_in_t in_reg;

  // Decode fields of the captured word
  logic [31:0] ins;
  logic [6:0]  opcode;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;

  decode_out_t dec;
  logic        bad;

  // The decoder never holds off a command.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_reg <= request;
    end
  end

  assign ins    = in_reg.instruction;
  assign opcode = ins[6:0];
  assign rd     = ins[11:7];
  assign f3     = ins[14:12];
  assign rs1    = ins[19:15];
  assign rs2    = ins[24:20];
  assign f7     = ins[31:25];

  // Sign-extended immediates of each format
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'h000};

  always_comb begin
    dec = '0;
    bad = 1'b0;
    unique case (opcode)
      OPC_OP: begin
        dec.src_reg_a        = rs1;
        dec.src_reg_b        = rs2;
        dec.dest_reg         = rd;
        dec.writeback_enable = 1'b1;
        dec.alu_op           = arith_alu(f3);
        if (f7 == F7_ALT && (f3 == F3_ADD_SUB || f3 == F3_SRL_SRA)) begin
          dec.alu_op = (f3 == F3_ADD_SUB) ? ALU_SUB : ALU_SRA;
        end else if (f7 != F7_BASE) begin
          bad = 1'b1;
        end
      end
      OPC_OP_IMM: begin
        dec.src_reg_a        = rs1;
        dec.dest_reg         = rd;
        dec.writeback_enable = 1'b1;
        dec.operand_select   = OSEL_REG_IMM;
        dec.immediate        = imm_i;
        dec.alu_op           = arith_alu(f3);
        if (f3 == F3_SLL || f3 == F3_SRL_SRA) begin
          // shift amount is the 5-bit shamt field only
          dec.immediate = {27'd0, rs2};
          if (f3 == F3_SRL_SRA && f7 == F7_ALT) begin
            dec.alu_op = ALU_SRA;
          end else if (f7 != F7_BASE) begin
            bad = 1'b1;
          end
        end
      end
      OPC_LOAD: begin
        dec.src_reg_a        = rs1;
        dec.dest_reg         = rd;
        dec.writeback_enable = 1'b1;
        dec.operand_select   = OSEL_REG_IMM;
        dec.alu_op           = ALU_ADD;
        dec.immediate        = imm_i;
        dec.mem_access       = load_kind(f3);
        bad                  = (load_kind(f3) == MEM_NONE);
      end
      OPC_JALR: begin
        dec.src_reg_a        = rs1;
        dec.dest_reg         = rd;
        dec.writeback_enable = 1'b1;
        dec.operand_select   = OSEL_REG_IMM;
        dec.alu_op           = ALU_ADD;
        dec.immediate        = imm_i;
        dec.jump_kind        = JMP_JALR;
        bad                  = (f3 != 3'd0);
      end
      OPC_STORE: begin
        dec.src_reg_a      = rs1;
        dec.src_reg_b      = rs2;
        dec.operand_select = OSEL_REG_IMM;
        dec.alu_op         = ALU_ADD;
        dec.immediate      = imm_s;
        dec.mem_access     = MEM_SB + {1'b0, f3};
        bad                = (f3 > 3'd2);
      end
      OPC_BRANCH: begin
        dec.src_reg_a     = rs1;
        dec.src_reg_b     = rs2;
        dec.jump_kind     = in_reg.predicted_taken ? JMP_BR_TAKEN : JMP_BR_NOT;
        dec.immediate     = imm_b;
        dec.branch_target = in_reg.pc + imm_b;
        dec.alu_op        = branch_alu(f3);
        bad               = (branch_alu(f3) == ALU_NONE);
      end
      OPC_LUI: begin
        dec.dest_reg         = rd;
        dec.writeback_enable = 1'b1;
        dec.operand_select   = OSEL_REG_IMM;
        dec.alu_op           = ALU_PASS;
        dec.immediate        = imm_u;
      end
      OPC_AUIPC: begin
        dec.dest_reg         = rd;
        dec.writeback_enable = 1'b1;
        dec.operand_select   = OSEL_PC_IMM;
        dec.alu_op           = ALU_ADD;
        dec.immediate        = imm_u;
      end
      OPC_JAL: begin
        dec.dest_reg         = rd;
        dec.writeback_enable = 1'b1;
        dec.jump_kind        = JMP_JAL;
        dec.immediate        = imm_j;
        dec.branch_target    = in_reg.pc + imm_j;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    // Any unsupported encoding collapses to a bare illegal flag.
    if (bad) begin
      dec         = '0;
      dec.illegal = 1'b1;
    end
  end

  // Stage 2: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= dec;
    end
  end

  // Every accepted command yields its result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result missing two cycles after command");

  // No result without a command held in the input register (in_valid).
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> !done)
    else $error("result strobe without a command");

  // An illegal result carries no other control.
  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.illegal |-> result.writeback_enable == 1'b0 &&
      result.mem_access == MEM_NONE && result.jump_kind == JMP_NONE &&
      result.alu_op == ALU_NONE && result.dest_reg == 5'd0)
    else $error("illegal result with live control fields");

  // A destination is named only when the register file is written.
  a_dest_wb: assert property (@(posedge clk) disable iff (rst)
    done && !result.writeback_enable |-> result.dest_reg == 5'd0)
    else $error("dest_reg set without writeback");

endmodule

`default_nettype wire
